>>> hw/rtl/tlg_pkg.sv
// tlg_pkg: shared constants for the toroidal life generation step unit.
// Holds opcodes, register indexes and the B3/S23 rule counts.
// No dependencies.
`default_nettype none

package tlg_pkg;

    // operation codes carried by an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // neighbour count type and the rule counts
    typedef logic [3:0] t_count;

    localparam t_count BIRTH_COUNT = 4'd3;
    localparam t_count SURVIVE_LOW = 4'd2;

endpackage : tlg_pkg

`default_nettype wire

>>> hw/rtl/tlg_grid_mem.sv
// tlg_grid_mem: cell grid storage, one row per entry.
// One write port and one read port, registered read data. No dependencies.
`default_nettype none

module tlg_grid_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read one row, data registered and out in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : tlg_grid_mem

`default_nettype wire

>>> hw/rtl/tlg_row_unit.sv
// tlg_row_unit: next generation of one grid row from a three-row window.
// Columns wrap at the last column in use. Depends on tlg_pkg.
`default_nettype none

module tlg_row_unit #(
    parameter int W = 64
) (
    input  wire logic [W-1:0]         i_prev,
    input  wire logic [W-1:0]         i_cur,
    input  wire logic [W-1:0]         i_next,
    input  wire logic [$clog2(W)-1:0] i_last_col,
    output logic      [W-1:0]         o_new,
    output logic                      o_changed
);

    import tlg_pkg::*;

    localparam int CAW = $clog2(W);

    logic [W-1:0] left_prev, left_cur, left_next;
    logic [W-1:0] sh_prev, sh_cur, sh_next;
    logic [W-1:0] right_prev, right_cur, right_next;
    t_count       cnt [W];

    // left neighbours: column zero wraps to the last column in use
    assign left_prev = {i_prev[W-2:0], i_prev[i_last_col]};
    assign left_cur  = {i_cur[W-2:0],  i_cur[i_last_col]};
    assign left_next = {i_next[W-2:0], i_next[i_last_col]};

    assign sh_prev = {1'b0, i_prev[W-1:1]};
    assign sh_cur  = {1'b0, i_cur[W-1:1]};
    assign sh_next = {1'b0, i_next[W-1:1]};

    // count and apply the rule lane by lane
    always_comb begin
        for (int c = 0; c < W; c++) begin
            // last column in use wraps right onto column zero
            if (CAW'(c) == i_last_col) begin
                right_prev[c] = i_prev[0];
                right_cur[c]  = i_cur[0];
                right_next[c] = i_next[0];
            end else begin
                right_prev[c] = sh_prev[c];
                right_cur[c]  = sh_cur[c];
                right_next[c] = sh_next[c];
            end
            cnt[c] = t_count'(left_prev[c]) + t_count'(i_prev[c]) + t_count'(right_prev[c])
                   + t_count'(left_cur[c])  + t_count'(right_cur[c])
                   + t_count'(left_next[c]) + t_count'(i_next[c]) + t_count'(right_next[c]);
            // columns beyond the area in use keep their value
            if (CAW'(c) <= i_last_col) begin
                o_new[c] = (cnt[c] == BIRTH_COUNT) || (i_cur[c] && (cnt[c] == SURVIVE_LOW));
            end else begin
                o_new[c] = i_cur[c];
            end
        end
    end

    assign o_changed = |(o_new ^ i_cur);

endmodule : tlg_row_unit

`default_nettype wire

>>> hw/rtl/toroidal_life_generation_step_unit.sv
// toroidal_life_generation_step_unit: B3/S23 life grid with toroidal wrap.
// Instantiates tlg_grid_mem and tlg_row_unit; depends on tlg_pkg.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  in       | to block  | i_in_valid / o_in_ready | i_opcode, i_row_index, i_col_index, i_cell_in
//  out      | from block| o_out_valid / i_out_ready | o_cell_out, o_grid_changed, o_status
//  cfg      | to block  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Cell write or read: row read, modify or pick, result. Bad coordinate or unused
// opcode: straight to the result. Generation step: reads of the last row and row zero,
// then one row per cycle through the row unit, limited by the single read port of the grid memory.
// After reset the block clears every grid row with o_in_ready low.
// One word is in work at a time; a new word is taken while a result waits in the
// output register, and a finished result waits there until taken.
`default_nettype none

module toroidal_life_generation_step_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_opcode,
    input  wire logic [5:0] i_row_index,
    input  wire logic [5:0] i_col_index,
    input  wire logic       i_cell_in,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_cell_out,
    output logic            o_grid_changed,
    output logic            o_status,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);

    import tlg_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int CCW = $clog2(MAX_COLS + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RMW    = 3'd2;
    localparam logic [2:0] ST_PRIME1 = 3'd3;
    localparam logic [2:0] ST_PRIME2 = 3'd4;
    localparam logic [2:0] ST_CALC   = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [6:0]          r_rows, r_cols;
    logic [AW-1:0]       r_row, n_row;
    logic [1:0]          r_op, n_op;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CAW-1:0]      r_col, n_col;
    logic                r_cell, n_cell;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_cur, n_cur;
    logic [MAX_COLS-1:0] r_row0, n_row0;
    logic                r_changed, n_changed;
    logic                r_res_cell, n_res_cell;
    logic                r_res_changed, n_res_changed;
    logic                r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic                r_out_cell, n_out_cell;
    logic                r_out_changed, n_out_changed;
    logic                r_out_status, n_out_status;

    logic [RCW-1:0]      nr;
    logic [CCW-1:0]      nc;
    logic [AW-1:0]       last_row;
    logic [CAW-1:0]      last_col;
    logic [AW:0]         ahead_row;
    logic                in_acc;
    logic                bad_coord;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [MAX_COLS-1:0] mem_wdata, mem_rdata;
    logic [MAX_COLS-1:0] next_row, unit_new, rmw_row;
    logic                unit_changed;

    // saturate the counts in use; a count of zero acts as one
    always_comb begin
        if (r_rows == 7'd0) begin
            nr = RCW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            nr = RCW'(MAX_ROWS);
        end else begin
            nr = RCW'(r_rows);
        end
        if (r_cols == 7'd0) begin
            nc = CCW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            nc = CCW'(MAX_COLS);
        end else begin
            nc = CCW'(r_cols);
        end
    end

    assign last_row  = AW'(nr - RCW'(1));
    assign last_col  = CAW'(nc - CCW'(1));
    assign ahead_row = {1'b0, r_row} + (AW + 1)'(2);
    assign in_acc    = i_in_valid && o_in_ready;
    assign bad_coord = (32'(i_row_index) >= 32'(nr)) || (32'(i_col_index) >= 32'(nc));
    assign next_row  = (r_row == last_row) ? r_row0 : mem_rdata;

    // modified row for a cell write
    always_comb begin
        rmw_row        = mem_rdata;
        rmw_row[r_col] = r_cell;
    end

    tlg_grid_mem #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tlg_row_unit #(
        .W (MAX_COLS)
    ) u_row (
        .i_prev     (r_prev),
        .i_cur      (r_cur),
        .i_next     (next_row),
        .i_last_col (last_col),
        .o_new      (unit_new),
        .o_changed  (unit_changed)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_op          = r_op;
        n_addr        = r_addr;
        n_col         = r_col;
        n_cell        = r_cell;
        n_prev        = r_prev;
        n_cur         = r_cur;
        n_row0        = r_row0;
        n_changed     = r_changed;
        n_res_cell    = r_res_cell;
        n_res_changed = r_res_changed;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_cell    = r_out_cell;
        n_out_changed = r_out_changed;
        n_out_status  = r_out_status;
        mem_we        = 1'b0;
        mem_waddr     = r_row;
        mem_wdata     = unit_new;
        mem_re        = 1'b0;
        mem_raddr     = r_addr;

        // drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_row;
                mem_wdata = '0;
                if (r_row == AW'(MAX_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_row = AW'(r_row + 1'b1);
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_op          = i_opcode;
                    n_addr        = AW'(i_row_index);
                    n_col         = CAW'(i_col_index);
                    n_cell        = i_cell_in;
                    n_res_cell    = 1'b0;
                    n_res_changed = 1'b0;
                    n_res_status  = 1'b0;
                    case (i_opcode) inside
                        OP_WRITE, OP_READ: begin
                            if (bad_coord) begin
                                n_res_status = 1'b1;
                                n_state      = ST_RESP;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(i_row_index);
                                n_state   = ST_RMW;
                            end
                        end
                        OP_STEP: begin
                            mem_re    = 1'b1;
                            mem_raddr = last_row;
                            n_state   = ST_PRIME1;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                if (r_op == OP_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    mem_wdata = rmw_row;
                end else begin
                    n_res_cell = mem_rdata[r_col];
                end
                n_state = ST_RESP;
            end
            ST_PRIME1: begin
                // last row arrives as the row above row zero
                n_prev    = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_state   = ST_PRIME2;
            end
            ST_PRIME2: begin
                // keep the old row zero for the wrap of the last row
                n_cur     = mem_rdata;
                n_row0    = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = (last_row == '0) ? '0 : AW'(1);
                n_row     = '0;
                n_changed = 1'b0;
                n_state   = ST_CALC;
            end
            ST_CALC: begin
                // write the new row in place, slide the window
                mem_we    = 1'b1;
                mem_waddr = r_row;
                mem_wdata = unit_new;
                n_changed = r_changed || unit_changed;
                n_prev    = r_cur;
                n_cur     = next_row;
                if (r_row == last_row) begin
                    n_res_changed = r_changed || unit_changed;
                    n_state       = ST_RESP;
                end else begin
                    n_row = AW'(r_row + 1'b1);
                    if (ahead_row <= {1'b0, last_row}) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(ahead_row);
                    end
                end
            end
            ST_RESP: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_cell    = r_res_cell;
                    n_out_changed = r_res_changed;
                    n_out_status  = r_res_status;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end else if (i_cfg_index == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    // payload and window
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_addr        <= n_addr;
        r_col         <= n_col;
        r_cell        <= n_cell;
        r_prev        <= n_prev;
        r_cur         <= n_cur;
        r_row0        <= n_row0;
        r_changed     <= n_changed;
        r_res_cell    <= n_res_cell;
        r_res_changed <= n_res_changed;
        r_res_status  <= n_res_status;
        r_out_cell    <= n_out_cell;
        r_out_changed <= n_out_changed;
        r_out_status  <= n_out_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_out     = r_out_cell;
    assign o_grid_changed = r_out_changed;
    assign o_status       = r_out_status;

`ifndef SYNTH
    a_calc_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_row <= last_row))
        else $error("row counter ran past the last row in use");

    a_step_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OP_STEP)) |=> (r_state == ST_PRIME1))
        else $error("accepted step did not start the row sweep");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("output word loaded outside the result state");

    a_step_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_res_changed) |-> (!r_res_status && !r_res_cell))
        else $error("step result carries read or error fields");

    a_out_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_cell_out && o_grid_changed))
        else $error("read value and grid change both set");
`endif

endmodule : toroidal_life_generation_step_unit

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for toroidal_life_generation_step_unit.
// Directed table, then bursts of seed, evolve and probe words over many grid sizes.
// Depends on tlg_pkg and the unit under test, which brings in tlg_grid_mem and tlg_row_unit.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlg_pkg::*;

    localparam int          GRID_ROWS    = 64;
    localparam int          GRID_COLS    = 64;
    localparam logic [1:0]  OP_NONE      = 2'd3;
    localparam int          RESET_CYCLES = 12;
    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          HOLD_CYCLES  = 500;
    localparam int          SETTLE       = 8;
    localparam int          TAIL_CYCLES  = 80;
    localparam int          PHASE_WORDS  = 120;
    localparam int          NUM_PHASES   = 14;
    localparam int          MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        logic       live;
    } t_life_word;

    typedef struct packed {
        logic value;
        logic changed;
        logic status;
    } t_life_result;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        t_life_word   word;
        logic         typed;
        t_life_result res;
        logic         cfg_idx;
        logic [6:0]   cfg_data;
    } t_table_row;

    // clock, reset and the driven inputs, all known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    t_life_word in_word     = '0;
    logic       out_ready   = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_idx     = 1'b0;
    logic [6:0] cfg_data    = '0;

    logic       in_ready;
    logic       out_valid;
    logic       out_cell;
    logic       out_changed;
    logic       out_status;

    // predictor state: grid copy and register copies
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    logic [6:0]           rows_reg;
    logic [6:0]           cols_reg;

    t_life_result pending_results [$];
    t_table_row   directed_rows   [$];

    int  cycle_count  = 0;
    int  error_count  = 0;
    int  words_sent   = 0;
    int  steps_sent   = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    bit  quiet        = 1'b0;
    bit  hold_req     = 1'b0;

    toroidal_life_generation_step_unit #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (in_word.op),
        .i_row_index   (in_word.row),
        .i_col_index   (in_word.col),
        .i_cell_in     (in_word.live),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_cell_out    (out_cell),
        .o_grid_changed(out_changed),
        .o_status      (out_status),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic int unsigned clamp_count(logic [6:0] v, int unsigned maxv);
        if (v == 7'd0) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    // advance one generation over the area in use; cells outside stay put
    function automatic logic advance_grid();
        logic [GRID_COLS-1:0] next_grid [GRID_ROWS];
        int unsigned nr, nc, n, rr, cc, r, c, dr, dc;
        logic alive, lives, changed;
        nr = clamp_count(rows_reg, GRID_ROWS);
        nc = clamp_count(cols_reg, GRID_COLS);
        changed = 1'b0;
        next_grid = life_grid;
        for (r = 0; r < nr; r++) begin
            for (c = 0; c < nc; c++) begin
                n = 0;
                // every wrapped neighbour position counts, even a repeat
                for (dr = 0; dr < 3; dr++) begin
                    for (dc = 0; dc < 3; dc++) begin
                        if (!(dr == 1 && dc == 1)) begin
                            rr = (r + nr + dr - 1) % nr;
                            cc = (c + nc + dc - 1) % nc;
                            n += 32'(life_grid[rr][cc]);
                        end
                    end
                end
                alive = life_grid[r][c];
                if (alive)
                    lives = (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
                else
                    lives = (n == BIRTH_COUNT);
                if (lives != alive) begin
                    changed = 1'b1;
                    next_grid[r][c] = lives;
                end
            end
        end
        life_grid = next_grid;
        return changed;
    endfunction

    function automatic t_life_result predict_word(t_life_word w);
        t_life_result res;
        int unsigned nr, nc;
        res.value = 1'b0;
        res.changed = 1'b0;
        res.status = 1'b0;
        nr = clamp_count(rows_reg, GRID_ROWS);
        nc = clamp_count(cols_reg, GRID_COLS);
        case (w.op)
            OP_WRITE, OP_READ: begin
                if (w.row >= nr || w.col >= nc)
                    res.status = 1'b1;
                else if (w.op == OP_WRITE)
                    life_grid[w.row][w.col] = w.live;
                else
                    res.value = life_grid[w.row][w.col];
            end
            OP_STEP: begin
                res.changed = advance_grid();
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_life_word area_word(logic [1:0] op);
        t_life_word w;
        w.op   = op;
        w.row  = 6'($urandom_range(0, clamp_count(rows_reg, GRID_ROWS) - 1));
        w.col  = 6'($urandom_range(0, clamp_count(cols_reg, GRID_COLS) - 1));
        w.live = ($urandom_range(0, 3) != 0);
        return w;
    endfunction

    function automatic t_life_word noise_word();
        t_life_word w;
        w.op   = 2'($urandom_range(0, 3));
        w.row  = 6'($urandom_range(0, 63));
        w.col  = 6'($urandom_range(0, 63));
        w.live = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // offer one word, hold it until taken, then queue its expected result
    task automatic send_word(t_life_word w, logic typed, t_life_result typed_res);
        t_life_result res;
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        res = predict_word(w);
        if (typed) res = typed_res;
        pending_results = {pending_results, res};
        words_sent++;
        if (w.op == OP_STEP) steps_sent++;
    endtask

    task automatic send_random(t_life_word w);
        send_word(w, 1'b0, '0);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [6:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_ROWS) rows_reg = data;
        else cols_reg = data;
        cfg_writes++;
    endtask

    task automatic add_word(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic v);
        t_table_row t;
        t = '0;
        t.kind = ROW_WORD;
        t.word = '{op: op, row: r, col: c, live: v};
        directed_rows = {directed_rows, t};
    endtask

    task automatic add_checked(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic v,
                               logic ec, logic eg, logic es);
        t_table_row t;
        t = '0;
        t.kind  = ROW_WORD;
        t.word  = '{op: op, row: r, col: c, live: v};
        t.typed = 1'b1;
        t.res   = '{value: ec, changed: eg, status: es};
        directed_rows = {directed_rows, t};
    endtask

    task automatic add_cfg(logic idx, logic [6:0] data);
        t_table_row t;
        t = '0;
        t.kind     = ROW_CFG;
        t.cfg_idx  = idx;
        t.cfg_data = data;
        directed_rows = {directed_rows, t};
    endtask

    // ---------------------------------------------------------------
    // receiver: random ready bursts plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_life_result want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d: c%0b g%0b s%0b",
                             cycle_count, out_cell, out_changed, out_status);
            end else begin
                want = pending_results.pop_front();
                if (want.value !== out_cell || want.changed !== out_changed ||
                    want.status !== out_status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch result %0d cycle %0d: %s c%0b g%0b s%0b, %s %0b%0b%0b",
                                 results_seen, cycle_count, "expected", want.value,
                                 want.changed, want.status, "got c/g/s",
                                 out_cell, out_changed, out_status);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [6:0] phase_rows [NUM_PHASES];
        logic [6:0] phase_cols [NUM_PHASES];
        t_table_row t;
        int p, sent, sel, n, k;

        phase_rows = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd0,  7'd6, 7'd8,
                       7'd12, 7'd16, 7'd100, 7'd3, 7'd64, 7'd7, 7'd64};
        phase_cols = '{7'd64, 7'd1, 7'd2, 7'd4, 7'd9, 7'd127, 7'd8,
                       7'd5,  7'd16, 7'd70, 7'd64, 7'd3,  7'd7, 7'd64};

        for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
        rows_reg = 7'd64;
        cols_reg = 7'd64;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty grid, extremes, wrap across both seams, tiny grids
        add_checked(OP_READ,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(OP_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        add_checked(OP_NONE,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0, 1'b0);
        add_checked(OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0, 1'b0);
        add_checked(OP_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b0);
        add_word(OP_WRITE, 6'd63, 6'd0,  1'b1);
        add_word(OP_WRITE, 6'd0,  6'd0,  1'b1);
        add_word(OP_WRITE, 6'd1,  6'd0,  1'b1);
        add_word(OP_WRITE, 6'd63, 6'd63, 1'b0);
        add_word(OP_STEP,  6'd0,  6'd0,  1'b0);
        add_word(OP_READ,  6'd0,  6'd63, 1'b0);
        add_word(OP_READ,  6'd1,  6'd0,  1'b0);
        // zero rows acts as one, oversized columns saturate
        add_cfg(CFG_ROWS, 7'd0);
        add_cfg(CFG_COLS, 7'd127);
        add_checked(OP_WRITE, 6'd1, 6'd0, 1'b1, 1'b0, 1'b0, 1'b1);
        add_word(OP_READ, 6'd0, 6'd40, 1'b0);
        add_word(OP_STEP, 6'd0, 6'd0,  1'b0);
        add_word(OP_READ, 6'd0, 6'd0,  1'b0);
        add_cfg(CFG_ROWS, 7'd2);
        add_cfg(CFG_COLS, 7'd2);
        add_checked(OP_WRITE, 6'd2, 6'd1, 1'b1, 1'b0, 1'b0, 1'b1);
        add_checked(OP_READ,  6'd1, 6'd2, 1'b0, 1'b0, 1'b0, 1'b1);
        add_word(OP_WRITE, 6'd1, 6'd1, 1'b1);
        add_word(OP_STEP,  6'd0, 6'd0, 1'b0);
        // cells outside the small area must survive the size change
        add_cfg(CFG_ROWS, 7'd64);
        add_cfg(CFG_COLS, 7'd64);
        add_word(OP_READ, 6'd1, 6'd0, 1'b0);
        add_word(OP_STEP, 6'd0, 6'd0, 1'b0);
        add_checked(OP_NONE, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);

        // walk the table
        foreach (directed_rows[i]) begin
            t = directed_rows[i];
            if (t.kind == ROW_CFG) begin
                drain();
                write_cfg(t.cfg_idx, t.cfg_data);
            end else begin
                send_word(t.word, t.typed, t.res);
            end
        end

        // random phases, one grid size each
        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_cfg(CFG_ROWS, phase_rows[p]);
            write_cfg(CFG_COLS, phase_cols[p]);
            if (p == 2) hold_req = 1'b1;
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                sel = $urandom_range(0, 99);
                if (sel < 40) begin
                    // seed a pattern
                    n = $urandom_range(2, 12);
                    repeat (n) send_random(area_word(OP_WRITE));
                    sent += n;
                end else if (sel < 75) begin
                    // evolve and look at the result
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        send_random(area_word(OP_STEP));
                        k = $urandom_range(0, 3);
                        repeat (k) send_random(area_word(OP_READ));
                        sent += 1 + k;
                    end
                end else if (sel < 90) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_random(area_word(OP_READ));
                    sent += n;
                end else begin
                    // noise: any opcode, any coordinate
                    n = $urandom_range(1, 4);
                    repeat (n) send_random(noise_word());
                    sent += n;
                end
            end
        end

        // wait out the last results, then a short tail
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        error_count += pending_results.size();

        $display("covered %0d words (%0d generation steps), %0d results, %0d register writes",
                 words_sent, steps_sent, results_seen, cfg_writes);
        $display("grid sizes from 1x1 to 64x64 incl. zero and saturated counts, %0d cycles",
                 cycle_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule : tb_top

`default_nettype wire

>>> files.f
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_grid_mem.sv
hw/rtl/tlg_row_unit.sv
hw/rtl/toroidal_life_generation_step_unit.sv
tb/tb_top.sv
